FILE: design/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants of the sine/cosine unit
// Word widths of the angle reduction and the series, and the bus that
// carries one item from one series term to the next.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int ANGLE_W     = 32;
  localparam int ANGLE_SHIFT = 24;
  localparam int AW          = 60;
  localparam int FW          = 52;
  localparam int MW          = 32;
  localparam int XW          = 33;
  localparam int NW          = 34;
  localparam int SW          = 35;
  localparam int RECIP_SHIFT = 34;

  localparam logic signed [AW-1:0] PI_Q48      = 60'sh3243F6A8885A3;
  localparam logic signed [AW-1:0] TWO_PI_Q48  = 60'sh6487ED5110B46;
  localparam logic signed [AW-1:0] HALF_PI_Q48 = 60'sh1921FB54442D2;

  typedef struct packed {
    logic                 valid;
    logic                 neg;
    logic [MW-1:0]        t;
    logic [XW-1:0]        x2;
    logic signed [SW-1:0] sum;
  } term_bus_t;

endpackage

FILE: design/sct_term.sv
// ----------------------------------------------------------------------------
// sct_term: one term of the odd Taylor series
// Multiplies the running term by x^2, divides by (n+1)(n+2) with rounding
// through a reciprocal multiply and one correction, and adds or subtracts it.
// ----------------------------------------------------------------------------
module sct_term import sct_pkg::*; #(
  parameter int TERM_INDEX = 1
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  term_bus_t din,
  output term_bus_t dout
);

  localparam int PW = MW + XW;
  localparam int D  = (2 * TERM_INDEX) * (2 * TERM_INDEX + 1);
  localparam int DW = $clog2(D + 1);
  localparam logic [DW-1:0] DIVISOR = DW'(D);
  localparam logic [NW-1:0] HALF_D  = NW'(D / 2);
  localparam logic [MW-1:0] RECIP   = MW'((64'd1 << RECIP_SHIFT) / D);
  localparam bit SUBTRACT = (TERM_INDEX % 2) == 1;

  term_bus_t         b1, b2, b3, b4;
  term_bus_t         dout_next;
  logic [PW-1:0]     p1;
  logic [NW-1:0]     n2, n3;
  logic [NW+MW-1:0]  q3;
  logic [MW-1:0]     qe4;
  logic [NW-1:0]     rem4;

  logic [PW-1:0]     p_round;
  logic [NW-1:0]     n_calc;
  logic [MW-1:0]     qe_calc;
  logic [MW+DW-1:0]  qd_calc;
  logic [MW-1:0]     t_calc;

  assign p_round = p1 + PW'(64'd1 << 30);
  assign n_calc  = p_round[31 +: NW] + HALF_D;
  assign qe_calc = q3[RECIP_SHIFT +: MW];
  assign qd_calc = qe_calc * DIVISOR;
  assign t_calc  = qe4 + MW'(rem4 >= NW'(DIVISOR));

  always_comb begin
    dout_next   = b4;
    dout_next.t = t_calc;
    if (SUBTRACT) begin
      dout_next.sum = b4.sum - $signed({{(SW-MW){1'b0}}, t_calc});
    end else begin
      dout_next.sum = b4.sum + $signed({{(SW-MW){1'b0}}, t_calc});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1.valid   <= 1'b0;
      b2.valid   <= 1'b0;
      b3.valid   <= 1'b0;
      b4.valid   <= 1'b0;
      dout.valid <= 1'b0;
    end else if (en) begin
      b1   <= din;
      p1   <= din.t * din.x2;
      b2   <= b1;
      n2   <= n_calc;
      b3   <= b2;
      n3   <= n2;
      q3   <= n2 * RECIP;
      b4   <= b3;
      qe4  <= qe_calc;
      rem4 <= n3 - qd_calc[NW-1:0];
      dout <= dout_next;
    end
  end

endmodule

FILE: design/sine_cosine_taylor.sv
// ----------------------------------------------------------------------------
// sine_cosine_taylor: pipelined sine and cosine by Taylor series
// Throughput is one item per cycle while the skid register is empty.
// Each series term is five register stages. A skid register behind the
// output lets the pipeline take one more item while a result waits.
// Reset clears all valid bits only.
// ----------------------------------------------------------------------------
module sine_cosine_taylor import sct_pkg::*; #(
  parameter int NUM_TERMS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // angle [31:0]
  input  logic        s_tuser,   // kind [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // value [31:0]
);

  localparam int FRONT  = 7;
  localparam int BH_LSB = 40;
  localparam int BH_W   = AW - BH_LSB;
  localparam int INV_W  = 23;
  localparam int PK_W   = BH_W + INV_W;
  localparam int K_LSB  = 32;
  localparam int K_W    = 8;
  localparam logic signed [INV_W-1:0] INV_TWO_PI = 23'sh28BE61;

  logic                   en;
  logic [FRONT-1:0]       fv;
  logic signed [AW-1:0]   b1, b2, r3, ar4;
  logic signed [PK_W-1:0] pk2;
  logic signed [FW-1:0]   f5;
  logic [MW-1:0]          m6, m7;
  logic                   neg6, neg7;
  logic [2*MW-1:0]        sq7;
  term_bus_t              term0;
  term_bus_t              bus [NUM_TERMS];
  logic                   res_valid;
  logic [31:0]            res;
  logic                   skid_valid;
  logic [31:0]            skid_data;

  logic signed [AW-1:0]   a_calc, b_calc, kt_calc, ar_calc, f_calc;
  logic signed [K_W-1:0]  k_calc;
  logic [FW-1:0]          mag_calc, mag_round;
  logic [2*MW-1:0]        sq_round;
  logic [SW-2:0]          s_calc;
  logic [SW-1:0]          s_plus;
  logic [SW-2:0]          v_calc;
  logic [31:0]            vc_calc;

  assign en       = !skid_valid;
  assign s_tready = en;

  assign a_calc = $signed({{(AW-ANGLE_W-ANGLE_SHIFT){s_tdata[ANGLE_W-1]}}, s_tdata,
                           {ANGLE_SHIFT{1'b0}}});
  assign b_calc = a_calc + (s_tuser ? HALF_PI_Q48 : '0) + PI_Q48;

  assign k_calc  = pk2[K_LSB +: K_W];
  assign kt_calc = k_calc * TWO_PI_Q48;

  always_comb begin
    if (r3 < 0) begin
      ar_calc = r3 + TWO_PI_Q48 - PI_Q48;
    end else if (r3 >= TWO_PI_Q48) begin
      ar_calc = r3 - TWO_PI_Q48 - PI_Q48;
    end else begin
      ar_calc = r3 - PI_Q48;
    end
  end

  always_comb begin
    if (ar4 > HALF_PI_Q48) begin
      f_calc = PI_Q48 - ar4;
    end else if (ar4 < -HALF_PI_Q48) begin
      f_calc = -PI_Q48 - ar4;
    end else begin
      f_calc = ar4;
    end
  end

  assign mag_calc  = f5[FW-1] ? FW'(-f5) : FW'(f5);
  assign mag_round = mag_calc + FW'(64'd1 << 16);
  assign sq_round  = sq7 + (2*MW)'(64'd1 << 30);

  always_ff @(posedge clk) begin
    if (en) begin
      b1    <= b_calc;
      b2    <= b1;
      pk2   <= $signed(b1[AW-1:BH_LSB]) * INV_TWO_PI;
      r3    <= b2 - kt_calc;
      ar4   <= ar_calc;
      f5    <= f_calc[FW-1:0];
      neg6  <= f5[FW-1];
      m6    <= mag_round[17 +: MW];
      neg7  <= neg6;
      m7    <= m6;
      sq7   <= m6 * m6;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv          <= '0;
      term0.valid <= 1'b0;
    end else if (en) begin
      fv          <= {fv[FRONT-2:0], s_tvalid};
      term0.valid <= fv[FRONT-1];
      term0.neg   <= neg7;
      term0.t     <= m7;
      term0.x2    <= sq_round[31 +: XW];
      term0.sum   <= $signed({{(SW-MW){1'b0}}, m7});
    end
  end

  assign bus[0] = term0;

  for (genvar g = 1; g < NUM_TERMS; g++) begin : g_term
    sct_term #(
      .TERM_INDEX(g)
    ) u_term (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .din (bus[g-1]),
      .dout(bus[g])
    );
  end

  assign s_calc  = bus[NUM_TERMS-1].sum[SW-1] ? '0 : bus[NUM_TERMS-1].sum[SW-2:0];
  assign s_plus  = {1'b0, s_calc} + SW'(1);
  assign v_calc  = s_plus[SW-1:1];
  assign vc_calc = (v_calc > (SW-1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : v_calc[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      res <= bus[NUM_TERMS-1].neg ? (32'd0 - vc_calc) : vc_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= bus[NUM_TERMS-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      m_tdata <= skid_valid ? skid_data : res;
    end else if (res_valid && !skid_valid) begin
      skid_data <= res;
    end
  end

  assert property (@(posedge clk) disable iff (rst) skid_valid |-> m_tvalid)
    else $error("Skid register holds an item while the output is empty.");

  assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_tvalid && !m_tready))
    else $error("Skid register filled without an output stall.");

  assert property (@(posedge clk) disable iff (rst)
    (skid_valid && m_tvalid && !m_tready) |=> (skid_valid && $stable(skid_data)))
    else $error("Skid item lost or changed during a stall.");

endmodule
